FILE: hdl/bss_pkg.sv
`timescale 1ns / 1ps
// Package for the byte stack: sizes, action and status codes.
package bss_pkg;

   localparam int DEPTH  = 32;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ACT_W  = 3;
   localparam int BYTE_W = 8;
   localparam int STAT_W = 2;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH   = 3'd0,
      ACT_POP    = 3'd1,
      ACT_PEEK   = 3'd2,
      ACT_SEARCH = 3'd3,
      ACT_DUMP   = 3'd4
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

endpackage

FILE: hdl/bss_req_if.sv
`timescale 1ns / 1ps
// Request channel of the byte stack: one action and its data byte per item.
interface bss_req_if
   import bss_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

FILE: hdl/bss_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the byte stack: one result per item.
interface bss_rsp_if
   import bss_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] value_byte;
   logic              has_value;
   logic              found;
   logic              now_empty;
   logic              last_of_run;
   logic [STAT_W-1:0] status;

   modport source (output valid, value_byte, has_value, found, now_empty, last_of_run,
                   status, input ready);
   modport sink   (input valid, value_byte, has_value, found, now_empty, last_of_run,
                   status, output ready);
endinterface

FILE: hdl/bss_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/byte_stack_with_search_unit.sv
`timescale 1ns / 1ps
// Top level of the byte stack with membership search and dump.
//
// A last-in-first-out store of up to DEPTH bytes held in one synchronous RAM.
// Each request item carries an action: push, pop, peek, search or dump. Every
// action gives one response item, except a dump of a non-empty stack, which
// gives one item per entry from top to bottom and sets last_of_run on the
// final one. Pop or peek on an empty stack reports underflow; a push onto a
// full stack reports overflow and drops the byte. Unused action codes give a
// single plain item and leave the stack alone. The block works on one item at
// a time: it takes a request only when the previous one is fully handed to
// the response register, and a response still waiting stalls the next result
// and so holds the request side back. Search reads one entry per cycle
// through the single read port of the entry RAM, and dump does so while the
// response side keeps taking items. The RAM needs no clearing after reset,
// since only entries below the fill count are read.
module byte_stack_with_search_unit
   import bss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   bss_req_if.sink          req_ch,
   bss_rsp_if.source        rsp_ch
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_SCAN = 5'b00100,
      S_SFIN = 5'b01000,
      S_TOP  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [BYTE_W-1:0] key_ff, key_in;

   // Response register.
   logic              ovalid_ff;
   logic [BYTE_W-1:0] ovalue_ff;
   logic              ohas_ff;
   logic              ofound_ff;
   logic              oempty_ff;
   logic              olast_ff;
   logic [STAT_W-1:0] ostatus_ff;

   // Result being produced in this cycle.
   logic              emit;
   logic [BYTE_W-1:0] e_value;
   logic              e_has;
   logic              e_found;
   logic              e_empty;
   logic              e_last;
   logic [STAT_W-1:0] e_status;

   // RAM access.
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic              rd_en;
   logic [PTR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0] rd_data;

   logic              out_free;
   logic              is_empty;
   logic              is_full;
   logic [PTR_W-1:0]  top_addr;

   bss_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A new result may be loaded when the register is empty or is being taken.
   assign out_free = !ovalid_ff || rsp_ch.ready;
   assign is_empty = (cnt_ff == '0);
   assign is_full  = (cnt_ff == FULL_CNT);
   assign top_addr = PTR_W'(cnt_ff - CNT_W'(1));

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      act_in   = act_ff;
      key_in   = key_ff;
      wr_en    = 1'b0;
      wr_addr  = PTR_W'(cnt_ff);
      rd_en    = 1'b0;
      rd_addr  = top_addr;
      emit     = 1'b0;
      e_value  = '0;
      e_has    = 1'b0;
      e_found  = 1'b0;
      e_empty  = is_empty;
      e_last   = 1'b1;
      e_status = ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               act_in   = req_ch.action;
               key_in   = req_ch.data_byte;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (act_ff)
               ACT_PUSH: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (is_full) begin
                        e_status = ST_OVER;
                     end else begin
                        wr_en   = 1'b1;
                        cnt_in  = cnt_ff + CNT_W'(1);
                        e_empty = 1'b0;
                     end
                  end
               end
               ACT_POP, ACT_PEEK, ACT_DUMP: begin
                  if (!is_empty) begin
                     // Fetch the top entry; it is emitted from S_TOP once the response register is free.
                     rd_en    = 1'b1;
                     rd_addr  = top_addr;
                     idx_in   = top_addr;
                     state_in = S_TOP;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     e_status = (act_ff == ACT_DUMP) ? ST_OK : ST_UNDER;
                     state_in = S_IDLE;
                  end
               end
               ACT_SEARCH: begin
                  if (!is_empty) begin
                     // Start the walk at the bottom entry.
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = PTR_W'(1);
                     hit_in   = 1'b0;
                     state_in = (cnt_ff == CNT_W'(1)) ? S_SFIN : S_SCAN;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end

         S_SCAN: begin
            // Read the next entry while comparing the one read last cycle.
            rd_en   = 1'b1;
            rd_addr = idx_ff;
            hit_in  = hit_ff | (rd_data == key_ff);
            idx_in  = idx_ff + PTR_W'(1);
            if (CNT_W'(idx_ff) == cnt_ff - CNT_W'(1)) begin
               state_in = S_SFIN;
            end
         end

         S_SFIN: begin
            // The last entry's data stays in the RAM output until taken.
            if (out_free) begin
               emit     = 1'b1;
               e_found  = hit_ff | (rd_data == key_ff);
               state_in = S_IDLE;
            end
         end

         S_TOP: begin
            if (out_free) begin
               emit    = 1'b1;
               e_value = rd_data;
               e_has   = 1'b1;
               e_empty = 1'b0;
               if (act_ff == ACT_POP) begin
                  cnt_in   = cnt_ff - CNT_W'(1);
                  e_empty  = (cnt_ff == CNT_W'(1));
                  state_in = S_IDLE;
               end else if (act_ff == ACT_DUMP) begin
                  // Walk downward; the bottom entry closes the run.
                  e_last = (idx_ff == '0);
                  if (idx_ff != '0) begin
                     rd_en   = 1'b1;
                     rd_addr = idx_ff - PTR_W'(1);
                     idx_in  = idx_ff - PTR_W'(1);
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      act_ff <= act_in;
      key_ff <= key_in;
      if (emit) begin
         ovalue_ff  <= e_value;
         ohas_ff    <= e_has;
         ofound_ff  <= e_found;
         oempty_ff  <= e_empty;
         olast_ff   <= e_last;
         ostatus_ff <= e_status;
      end
   end

   assign rsp_ch.valid       = ovalid_ff;
   assign rsp_ch.value_byte  = ovalue_ff;
   assign rsp_ch.has_value   = ohas_ff;
   assign rsp_ch.found       = ofound_ff;
   assign rsp_ch.now_empty   = oempty_ff;
   assign rsp_ch.last_of_run = olast_ff;
   assign rsp_ch.status      = ostatus_ff;

   // The fill count never passes the capacity of the RAM.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("fill count above capacity");

   // Overflow is reported only when the stack is actually full.
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      (emit && e_status == ST_OVER) |-> is_full)
      else $error("overflow reported on a stack that is not full");

   // A completed pop lowers the fill count by exactly one.
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == S_TOP && act_ff == ACT_POP)
         |=> cnt_ff == $past(cnt_ff) - CNT_W'(1))
      else $error("pop did not lower the fill count by one");

   // The search walk only reads positions below the fill count.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> CNT_W'(idx_ff) < cnt_ff)
      else $error("search read beyond the held entries");

   // A result never overwrites one that is still waiting to be taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp_ch.ready) |-> !emit)
      else $error("result register overwritten while stalled");

endmodule

FILE: tb/byte_stack_with_search_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the byte stack: directed, full-stack and random action runs.
module byte_stack_with_search_unit_tb;
   import bss_pkg::*;

   // Timing of the bench. The drain figure scales with DEPTH, the length of a
   // dump of a full stack.
   localparam int RANDOM_ITEMS    = 105;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 2 * DEPTH + 8;
   localparam int IDLE_LIMIT      = 2000;

   // Action codes above dump are not defined; the block must answer them plainly.
   localparam logic [ACT_W-1:0] FIRST_SPARE_ACT = ACT_W'(ACT_DUMP + 1);
   localparam logic [ACT_W-1:0] LAST_SPARE_ACT  = '1;

   typedef struct {
      logic [BYTE_W-1:0] value_byte;
      logic              has_value;
      logic              found;
      logic              now_empty;
      logic              last_of_run;
      status_type        status;
   } stack_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bss_req_if req_ch ();
   bss_rsp_if rsp_ch ();

   byte_stack_with_search_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the stack, updated when a request item is accepted.
   logic [BYTE_W-1:0] stack_mem [DEPTH];
   int                stack_fill = 0;
   stack_rsp_type     pending_rsps [$];

   int  error_count     = 0;
   int  n_requests      = 0;
   int  n_responses     = 0;
   int  n_overflows     = 0;
   int  n_underflows    = 0;
   int  n_search_hits   = 0;
   int  n_dump_entries  = 0;
   int  idle_cycles     = 0;

   // steady_run turns off all idling on both sides for a stretch of the random
   // test; hold_rsp_request asks the response side for one long hold-off.
   bit  steady_run       = 1'b0;
   bit  hold_rsp_request = 1'b0;

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_run)
         return 0;
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Builds one expected response; the empty flag reflects the stack after the action.
   function automatic stack_rsp_type make_rsp(logic [BYTE_W-1:0] val, logic has, logic fnd,
                                              logic last, status_type st);
      stack_rsp_type r;
      r.value_byte  = val;
      r.has_value   = has;
      r.found       = fnd;
      r.now_empty   = (stack_fill == 0);
      r.last_of_run = last;
      r.status      = st;
      return r;
   endfunction

   // Applies one accepted action to the shadow stack and queues every response it causes.
   task automatic predict_action(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] data);
      bit hit;
      int i;
      n_requests++;
      case (act)
         ACT_PUSH: begin
            if (stack_fill == DEPTH) begin
               // A push onto a full stack is dropped and flagged.
               n_overflows++;
               pending_rsps.push_back(make_rsp('0, 1'b0, 1'b0, 1'b1, ST_OVER));
            end else begin
               stack_mem[stack_fill] = data;
               stack_fill++;
               pending_rsps.push_back(make_rsp('0, 1'b0, 1'b0, 1'b1, ST_OK));
            end
         end
         ACT_POP, ACT_PEEK: begin
            if (stack_fill == 0) begin
               n_underflows++;
               pending_rsps.push_back(make_rsp('0, 1'b0, 1'b0, 1'b1, ST_UNDER));
            end else begin
               if (act == ACT_POP)
                  stack_fill--;
               pending_rsps.push_back(make_rsp(stack_mem[act == ACT_POP ? stack_fill
                                                                       : stack_fill - 1],
                                               1'b1, 1'b0, 1'b1, ST_OK));
            end
         end
         ACT_SEARCH: begin
            hit = 1'b0;
            for (i = 0; i < stack_fill; i++)
               if (stack_mem[i] == data)
                  hit = 1'b1;
            if (hit)
               n_search_hits++;
            pending_rsps.push_back(make_rsp('0, 1'b0, hit, 1'b1, ST_OK));
         end
         ACT_DUMP: begin
            // An empty dump still answers once, with no value.
            if (stack_fill == 0)
               pending_rsps.push_back(make_rsp('0, 1'b0, 1'b0, 1'b1, ST_OK));
            for (i = 0; i < stack_fill; i++) begin
               n_dump_entries++;
               pending_rsps.push_back(make_rsp(stack_mem[stack_fill - 1 - i], 1'b1, 1'b0,
                                               i == stack_fill - 1, ST_OK));
            end
         end
         default: begin
            pending_rsps.push_back(make_rsp('0, 1'b0, 1'b0, 1'b1, ST_OK));
         end
      endcase
   endtask

   // Offers one item, waits for the handshake, then idles for a random gap.
   // With no gap, valid stays high and the next call simply updates the payload.
   task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] data);
      int gap;
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.data_byte <= data;
      do
         @(posedge clock);
      while (!(req_ch.valid && req_ch.ready));
      predict_action(act, data);
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid     <= 1'b0;
         req_ch.action    <= ACT_W'($urandom);
         req_ch.data_byte <= BYTE_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Search keys come from the stack most of the time so that hits are common.
   function automatic logic [BYTE_W-1:0] search_key();
      if (stack_fill > 0 && $urandom_range(0, 2) != 0)
         return stack_mem[$urandom_range(0, stack_fill - 1)];
      return BYTE_W'($urandom);
   endfunction

   // Push-heavy while the stack is shallow, less so near the top, so the depth
   // wanders over the whole range and touches both empty and full.
   function automatic logic [ACT_W-1:0] random_action();
      int r;
      int push_pct;
      r = $urandom_range(0, 99);
      push_pct = (stack_fill > 24) ? 25 : 40;
      if (r < 5)
         return ACT_W'($urandom_range(LAST_SPARE_ACT, FIRST_SPARE_ACT));
      if (r < 5 + push_pct)
         return ACT_PUSH;
      if (r < 5 + push_pct + 22)
         return ACT_POP;
      if (r < 5 + push_pct + 32)
         return ACT_PEEK;
      if (r < 5 + push_pct + 47)
         return ACT_SEARCH;
      return ACT_DUMP;
   endfunction

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Pop, peek, dump and search on an empty stack, plus the undefined action codes.
   task automatic test_empty_stack();
      send_item(ACT_POP, 8'h00);
      send_item(ACT_PEEK, 8'hFF);
      send_item(ACT_DUMP, 8'h00);
      send_item(ACT_SEARCH, 8'h00);
      send_item(FIRST_SPARE_ACT, 8'hFF);
      send_item(FIRST_SPARE_ACT + 1'b1, 8'h00);
      send_item(LAST_SPARE_ACT, 8'hA5);
   endtask

   // Extremes of the data byte, hits and a miss, a short dump and pops back to empty.
   task automatic test_basic_ops();
      send_item(ACT_PUSH, 8'h00);
      send_item(ACT_PUSH, 8'hFF);
      send_item(ACT_PUSH, 8'h5A);
      send_item(ACT_PEEK, 8'h00);
      send_item(ACT_SEARCH, 8'hFF);
      send_item(ACT_SEARCH, 8'h00);
      send_item(ACT_SEARCH, 8'h01);
      send_item(ACT_DUMP, 8'hFF);
      send_item(ACT_POP, 8'h00);
      send_item(ACT_POP, 8'hFF);
      send_item(ACT_POP, 8'h00);
      send_item(ACT_POP, 8'h00);
   endtask

   // Fills the stack, pushes past the top, then dumps every entry while the
   // response side holds off for a long time and the request side keeps offering.
   task automatic test_fill_and_overflow();
      int k;
      while (stack_fill < DEPTH)
         send_item(ACT_PUSH, BYTE_W'($urandom));
      send_item(ACT_PUSH, 8'hFF);
      send_item(ACT_PUSH, 8'h00);
      send_item(ACT_SEARCH, stack_mem[$urandom_range(0, DEPTH - 1)]);
      send_item(ACT_PEEK, BYTE_W'($urandom));
      hold_rsp_request = 1'b1;
      send_item(ACT_DUMP, BYTE_W'($urandom));
      for (k = 0; k < 4; k++)
         send_item(ACT_POP, BYTE_W'($urandom));
      while (stack_fill > DEPTH / 2)
         send_item(ACT_POP, BYTE_W'($urandom));
   endtask

   // Random mix; a middle stretch runs with no idling on either side.
   task automatic test_random_mix();
      int n;
      logic [ACT_W-1:0] act;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady_run = (n >= 40 && n < 70);
         act = random_action();
         send_item(act, (act == ACT_SEARCH) ? search_key() : BYTE_W'($urandom));
      end
      steady_run = 1'b0;
   endtask

   // Response side: random ready pattern, with one long hold-off on request.
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      do
         @(posedge clock);
      while (reset);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_ch.ready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Response checker: each accepted response against the oldest expectation.
   always @(posedge clock) begin
      stack_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_responses++;
         if (pending_rsps.size() == 0) begin
            error_count++;
            $error("response with no expectation waiting: value_byte %0d status %0d",
                   rsp_ch.value_byte, rsp_ch.status);
         end else begin
            want = pending_rsps.pop_front();
            check_field("value_byte", want.value_byte, rsp_ch.value_byte);
            check_field("has_value", BYTE_W'(want.has_value), BYTE_W'(rsp_ch.has_value));
            check_field("found", BYTE_W'(want.found), BYTE_W'(rsp_ch.found));
            check_field("now_empty", BYTE_W'(want.now_empty), BYTE_W'(rsp_ch.now_empty));
            check_field("last_of_run", BYTE_W'(want.last_of_run),
                        BYTE_W'(rsp_ch.last_of_run));
            check_field("status", BYTE_W'(want.status), BYTE_W'(rsp_ch.status));
         end
      end
   end

   // Watchdog: too many cycles in a row with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
                  idle_cycles, pending_rsps.size());
         $display("byte_stack_with_search_unit_tb failed");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= ACT_PUSH;
      req_ch.data_byte <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_basic_ops();
      test_fill_and_overflow();
      test_random_mix();

      req_ch.valid <= 1'b0;
      while (pending_rsps.size() != 0)
         @(posedge clock);
      // Let any stray extra responses show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d actions giving %0d responses, %0d of them dumped entries.",
               n_requests, n_responses, n_dump_entries);
      $display("Saw %0d overflows, %0d underflows and %0d search hits, with one long stall.",
               n_overflows, n_underflows, n_search_hits);
      if (error_count == 0)
         $display("byte_stack_with_search_unit_tb passed");
      else
         $display("byte_stack_with_search_unit_tb failed");
      $finish;
   end

endmodule
